FILE: rtl/button_click_hold_classifier_macros.svh
// assertion helpers shared by the rtl
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCHC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bchc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bchc_pkg;

  // sizes
  localparam int NUM_BUTTONS = 64;
  localparam int BTN_AW      = $clog2(NUM_BUTTONS);
  localparam int INDEX_W     = 6;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int RING_DEPTH  = 4;
  localparam int RING_AW     = 2;

  // ring distance back to the previous release
  localparam logic [RING_AW-1:0] PREV_RELEASE_OFFSET = RING_AW'(2);

  // event codes
  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_CLICK  = 3'd2,
    EV_DOUBLE = 3'd3,
    EV_HOLD   = 3'd4
  } event_code_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DOUBLE_CLICK_MS = 2'd0,
    CFG_HOLD_MS         = 2'd1,
    CFG_BASE_ADDRESS    = 2'd2
  } cfg_index_t;

  // input beat
  typedef struct packed {
    logic [INDEX_W-1:0] button_index;
    logic               pressed;
    logic [TIME_W-1:0]  now_ms;
  } sample_t;

  // result beat
  typedef struct packed {
    logic [CFG_W-1:0] button_address;
    logic [2:0]       event_code;
    logic             last_event;
  } result_t;

  // per-button record held in the state memory
  typedef struct packed {
    logic                                down;
    logic [RING_AW-1:0]                  ptr;
    logic [TIME_W-1:0]                   hold_time;
    logic [RING_DEPTH-1:0][TIME_W-1:0]   times;
  } btn_row_t;

  // classifier outcome for one sample
  typedef struct packed {
    logic        wr_en;
    btn_row_t    row;
    logic [1:0]  count;
    event_code_t ev0;
    event_code_t ev1;
  } class_t;

endpackage

`default_nettype wire

FILE: rtl/bchc_state_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bchc_state_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [bchc_pkg::BTN_AW-1:0] rd_addr,
  input  wire logic                       wr_en,
  input  wire logic [bchc_pkg::BTN_AW-1:0] wr_addr,
  input  wire bchc_pkg::btn_row_t         wr_row,
  output bchc_pkg::btn_row_t              rd_row
);

  bchc_pkg::btn_row_t mem [bchc_pkg::NUM_BUTTONS];
  bchc_pkg::btn_row_t rd_data;
  logic [bchc_pkg::NUM_BUTTONS-1:0] valid;
  logic rd_valid;
  logic same_addr;

  assign same_addr = wr_en && (wr_addr == rd_addr);

  // storage array with registered read, write data forwarded on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= same_addr ? wr_row : mem[rd_addr];
    end
  end

  // one valid bit per row, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr] | same_addr;
      end
    end
  end

  // a row never written reads as released with an empty ring
  assign rd_row = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

FILE: rtl/bchc_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module bchc_classify (
  input  wire bchc_pkg::sample_t              sample,
  input  wire bchc_pkg::btn_row_t             row,
  input  wire logic [bchc_pkg::CFG_W-1:0]     double_click_ms,
  input  wire logic [bchc_pkg::CFG_W-1:0]     hold_ms,
  output bchc_pkg::class_t                    cls
);

  localparam int PAD_W = bchc_pkg::TIME_W - bchc_pkg::CFG_W;

  logic [bchc_pkg::RING_AW-1:0] p;
  logic [bchc_pkg::RING_AW-1:0] q;
  logic [bchc_pkg::TIME_W-1:0]  prev;
  logic [bchc_pkg::TIME_W-1:0]  gap;
  logic [bchc_pkg::TIME_W-1:0]  hold_ext;
  logic [bchc_pkg::TIME_W-1:0]  dc_ext;

  assign hold_ext = {{PAD_W{1'b0}}, hold_ms};
  assign dc_ext   = {{PAD_W{1'b0}}, double_click_ms};

  // ring slots: the new change and the release two slots back
  assign p    = row.ptr + bchc_pkg::RING_AW'(1);
  assign q    = p + bchc_pkg::PREV_RELEASE_OFFSET;
  assign prev = row.times[q];
  assign gap  = sample.now_ms - prev;

  // modify the record and pick the events
  always_comb begin
    cls       = '0;
    cls.row   = row;
    cls.ev0   = bchc_pkg::EV_DOWN;
    cls.ev1   = bchc_pkg::EV_CLICK;
    if (sample.pressed != row.down) begin
      cls.wr_en        = 1'b1;
      cls.row.ptr      = p;
      cls.row.times[p] = sample.now_ms;
      cls.row.down     = sample.pressed;
      if (sample.pressed) begin
        cls.ev0           = bchc_pkg::EV_DOWN;
        cls.count         = 2'd1;
        cls.row.hold_time = sample.now_ms + hold_ext;
      end else begin
        cls.ev0   = bchc_pkg::EV_UP;
        cls.count = 2'd2;
        cls.ev1   = ((prev != '0) && (gap < dc_ext)) ? bchc_pkg::EV_DOUBLE
                                                     : bchc_pkg::EV_CLICK;
      end
    end else if (sample.pressed && (sample.now_ms > row.hold_time)) begin
      cls.wr_en         = 1'b1;
      cls.ev0           = bchc_pkg::EV_HOLD;
      cls.count         = 2'd1;
      cls.row.hold_time = row.hold_time + hold_ext;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/button_click_hold_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
`include "button_click_hold_classifier_macros.svh"

// channel   handshake               payload
// sample    start / busy            sample (button_index, pressed, now_ms)
// result    result_valid strobe     result (button_address, event_code, last_event)
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a sample goes through the registered state memory read, then modify and write back;
// a release with two result beats also passes through ST_SECOND for its second beat.
// busy stays high until the last result is loaded; that beat overlaps
// the next sample's read.
// rst is synchronous; per-button rows are marked empty by valid bits at once,
// so no clearing pass is needed. results cannot be stalled; cfg_ready is always high.

module button_click_hold_classifier (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire bchc_pkg::sample_t            sample,
  output bchc_pkg::result_t                 result,
  output logic                              result_valid,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [bchc_pkg::CFG_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_SECOND = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [bchc_pkg::CFG_W-1:0] double_click_ms;
  logic [bchc_pkg::CFG_W-1:0] hold_ms;
  logic [bchc_pkg::CFG_W-1:0] base_address;

  bchc_pkg::sample_t     sample_q;
  bchc_pkg::btn_row_t    rd_row;
  bchc_pkg::class_t      cls;
  bchc_pkg::event_code_t ev1_q;
  logic                  accept;
  logic                  in_range;
  logic [bchc_pkg::CFG_W-1:0] addr_sum;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = {1'b0, sample.button_index}
                     < (bchc_pkg::INDEX_W + 1)'(bchc_pkg::NUM_BUTTONS);
  assign addr_sum  = base_address
                     + {{(bchc_pkg::CFG_W - bchc_pkg::INDEX_W){1'b0}}, sample_q.button_index};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      double_click_ms <= bchc_pkg::CFG_W'(500);
      hold_ms         <= bchc_pkg::CFG_W'(1000);
      base_address    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bchc_pkg::CFG_DOUBLE_CLICK_MS: double_click_ms <= cfg_data;
        bchc_pkg::CFG_HOLD_MS:         hold_ms         <= cfg_data;
        bchc_pkg::CFG_BASE_ADDRESS:    base_address    <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-button state memory
  bchc_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (sample.button_index[bchc_pkg::BTN_AW-1:0]),
    .wr_en   ((state == ST_EXEC) && cls.wr_en),
    .wr_addr (sample_q.button_index[bchc_pkg::BTN_AW-1:0]),
    .wr_row  (cls.row),
    .rd_row  (rd_row)
  );

  // event decision on the fetched row
  bchc_classify u_classify (
    .sample          (sample_q),
    .row             (rd_row),
    .double_click_ms (double_click_ms),
    .hold_ms         (hold_ms),
    .cls             (cls)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && in_range) state_next = ST_EXEC;
      ST_EXEC:   state_next = (cls.count == 2'd2) ? ST_SECOND : ST_IDLE;
      ST_SECOND: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= ((state == ST_EXEC) && (cls.count != 2'd0)) || (state == ST_SECOND);
    end
  end

  // sample and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
    end
    if (state == ST_EXEC) begin
      result.button_address <= addr_sum;
      result.event_code     <= cls.ev0;
      result.last_event     <= (cls.count == 2'd1);
      ev1_q                 <= cls.ev1;
    end else if (state == ST_SECOND) begin
      result.event_code <= ev1_q;
      result.last_event <= 1'b1;
    end
  end

  // checks
  `BCHC_ASSERT_NEXT(a_second_beat_follows, result_valid && !result.last_event,
                    result_valid, "second result beat missing")
  `BCHC_ASSERT_SAME(a_click_is_last,
                    result_valid && ((result.event_code == bchc_pkg::EV_CLICK)
                                     || (result.event_code == bchc_pkg::EV_DOUBLE)),
                    result.last_event, "click beat not marked last")
  `BCHC_ASSERT_SAME(a_up_not_last, result_valid && (result.event_code == bchc_pkg::EV_UP),
                    !result.last_event, "up beat marked last")
  `BCHC_ASSERT_NEXT(a_accept_executes, accept && in_range, state == ST_EXEC,
                    "accepted sample not executed")
  `BCHC_ASSERT_SAME(a_second_after_first, state == ST_SECOND,
                    result_valid && (result.event_code == bchc_pkg::EV_UP),
                    "second beat without up beat")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bchc_pkg::*;

  // tracks per-button state and the queue of events the block should emit
  class click_scoreboard;
    logic [15:0]  double_ms;
    logic [15:0]  hold_delay;
    logic [15:0]  base_addr;
    logic         is_down [NUM_BUTTONS];
    logic [1:0]   ring_ptr [NUM_BUTTONS];
    logic [31:0]  change_time [NUM_BUTTONS][4];
    logic [31:0]  hold_due [NUM_BUTTONS];
    result_t      expected_events [$];
    int           mismatches;

    function new();
      double_ms  = 16'd500;
      hold_delay = 16'd1000;
      base_addr  = 16'd0;
      mismatches = 0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        is_down[b]  = 1'b0;
        ring_ptr[b] = 2'd0;
        hold_due[b] = 32'd0;
        for (int e = 0; e < 4; e++) change_time[b][e] = 32'd0;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function int pending();
      return expected_events.size();
    endfunction

    function void apply_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_DOUBLE_CLICK_MS: double_ms  = value;
        CFG_HOLD_MS:         hold_delay = value;
        CFG_BASE_ADDRESS:    base_addr  = value;
        default: ;
      endcase
    endfunction

    // predict the events caused by one accepted sample beat
    function void note_sample(sample_t s);
      int unsigned  b;
      int           n;
      logic [1:0]   p;
      logic [1:0]   q;
      logic [31:0]  prev;
      logic [31:0]  gap;
      logic [15:0]  addr;
      event_code_t  codes [2];
      result_t      r;
      b = s.button_index;
      if (b >= NUM_BUTTONS) return;
      addr = base_addr + 16'(s.button_index);
      n = 0;
      if (s.pressed != is_down[b]) begin
        p = ring_ptr[b] + 2'd1;
        ring_ptr[b] = p;
        change_time[b][p] = s.now_ms;
        is_down[b] = s.pressed;
        if (s.pressed) begin
          codes[n] = EV_DOWN;
          n++;
          hold_due[b] = s.now_ms + {16'h0, hold_delay};
        end else begin
          // release two changes back, zero means none recorded
          q = p + PREV_RELEASE_OFFSET;
          prev = change_time[b][q];
          gap = s.now_ms - prev;
          codes[n] = EV_UP;
          n++;
          if (prev != 32'd0 && gap < {16'h0, double_ms}) codes[n] = EV_DOUBLE;
          else codes[n] = EV_CLICK;
          n++;
        end
      end else if (s.pressed && s.now_ms > hold_due[b]) begin
        codes[n] = EV_HOLD;
        n++;
        hold_due[b] = hold_due[b] + {16'h0, hold_delay};
      end
      for (int i = 0; i < n; i++) begin
        r.button_address = addr;
        r.event_code     = codes[i];
        r.last_event     = (i == n - 1);
        expected_events.push_back(r);
      end
    endfunction

    // compare one result beat against the oldest expected event
    task check_event(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result addr=%0d code=%0d last=%0d",
                                  got.button_address, got.event_code, got.last_event));
        return;
      end
      want = expected_events.pop_front();
      if (got.button_address !== want.button_address)
        report_mismatch($sformatf("button_address got %0d want %0d",
                                  got.button_address, want.button_address));
      if (got.event_code !== want.event_code)
        report_mismatch($sformatf("event_code got %0d want %0d (addr %0d)",
                                  got.event_code, want.event_code, want.button_address));
      if (got.last_event !== want.last_event)
        report_mismatch($sformatf("last_event got %0d want %0d (addr %0d code %0d)",
                                  got.last_event, want.last_event,
                                  want.button_address, want.event_code));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  sample_t     sample;
  result_t     result;
  logic        result_valid;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  click_scoreboard sb;
  logic            no_idle;

  button_click_hold_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_event(result);
      if (start && !busy) sb.note_sample(sample);
      if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
    end
  end

  // one sample beat, with a random idle gap ahead of it
  task automatic send(sample_t s);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
  endtask

  task automatic press(int unsigned idx, logic pr, logic [31:0] now);
    sample_t s;
    s.button_index = 6'(idx);
    s.pressed      = pr;
    s.now_ms       = now;
    send(s);
  endtask

  // drop start, then wait for all events plus the block's pipeline depth
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_registers(logic [15:0] dbl, logic [15:0] hold, logic [15:0] base);
    settle();
    write_register(CFG_DOUBLE_CLICK_MS, dbl);
    write_register(CFG_HOLD_MS, hold);
    write_register(CFG_BASE_ADDRESS, base);
  endtask

  // random click/hold traffic on a few busy buttons plus noise
  task automatic run_phase(int count, int unsigned step_max);
    logic [5:0]  pool [4];
    logic [31:0] t;
    sample_t     s;
    int unsigned k;
    for (int i = 0; i < 4; i++) pool[i] = 6'($urandom_range(0, 63));
    t = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      k = $urandom_range(0, 99);
      s.button_index = (k < 90) ? pool[$urandom_range(0, 3)] : 6'($urandom_range(0, 63));
      s.pressed = ($urandom_range(0, 9) < 6) ? ~sb.is_down[s.button_index]
                                             : sb.is_down[s.button_index];
      t = t + $urandom_range(0, step_max);
      s.now_ms = (k >= 95) ? 32'($urandom) : t;
      send(s);
    end
  endtask

  // main sequence
  initial begin
    sb        = new();
    no_idle   = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: hold at the boundary, click then double click
    press(0, 1'b1, 32'd100);
    press(0, 1'b1, 32'd1100);
    press(0, 1'b1, 32'd1101);
    press(0, 1'b0, 32'd1200);
    press(0, 1'b0, 32'd1250);
    press(0, 1'b1, 32'd1300);
    press(0, 1'b0, 32'd1400);
    // hold time wrapping past the top of the time range
    press(63, 1'b1, 32'hFFFF_FFF0);
    press(63, 1'b1, 32'hFFFF_FFF8);
    press(63, 1'b0, 32'hFFFF_FFFF);
    // release recorded at time zero does not count as a previous release
    press(2, 1'b1, 32'd10);
    press(2, 1'b0, 32'd0);
    press(2, 1'b1, 32'd20);
    press(2, 1'b0, 32'd30);

    // zero hold delay, zero double click window, address wrap
    set_registers(16'd0, 16'd0, 16'hFFFF);
    press(42, 1'b1, 32'd5);
    press(42, 1'b1, 32'd5);
    press(42, 1'b1, 32'd6);
    press(42, 1'b1, 32'd7);
    press(42, 1'b0, 32'd8);
    press(42, 1'b1, 32'd9);
    press(42, 1'b0, 32'd10);

    // random phases across a spread of settings
    set_registers(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom));
    run_phase(310, 8000);
    set_registers(16'd0, 16'd1, 16'hFFFF);
    run_phase(310, 4);
    set_registers(16'hFFFF, 16'hFFFF, 16'd0);
    run_phase(310, 20000);
    set_registers(16'($urandom_range(100, 1000)), 16'd0, 16'($urandom));
    run_phase(310, 60);
    set_registers(16'($urandom_range(0, 3000)), 16'($urandom_range(1, 200)), 16'($urandom));
    run_phase(310, 400);
    set_registers(16'd300, 16'd800, 16'hFFC0);
    run_phase(310, 250);

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
